// ----- hw/rtl/auv_pkg.sv -----
// ----------------------------------------------------------------------------
// auv_pkg
// Shared types, constants and small helpers for the angles-to-unit-vector core.
// ----------------------------------------------------------------------------
package auv_pkg;

	localparam int AUV_ANGLE_BITS = 16;
	localparam int CORDIC_N       = 28;
	// z stage, CORDIC_N rotations, square stage
	localparam int CORDIC_LAT     = CORDIC_N + 2;
	localparam int DIV_Q_BITS     = 31;
	localparam int SQRT_STEPS     = 31;

	localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef logic [30:0] q30_t;

	typedef struct packed {
		logic signed [15:0] angle_xy;
		logic signed [15:0] angle_yz;
		logic signed [15:0] angle_zx;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] comp_x;
		logic signed [15:0] comp_y;
		logic signed [15:0] comp_z;
	} vec_t;

	// solve plan for one word, fixed once the angles are ranked
	typedef struct packed {
		logic       dim3;
		logic       ge2;
		logic       ge1;
		logic [1:0] r0;
		logic [1:0] r1;
		logic       flip;
		logic [1:0] pivot3;
		logic       neg3;
		logic [1:0] e_idx;
		logic [1:0] pivot2;
		logic       neg2;
		logic [1:0] pivot1;
		logic       neg1;
	} ctl_t;

	function automatic logic [31:0] atan_q(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'd536870912;
			1:  r = 32'd316933406;
			2:  r = 32'd167458907;
			3:  r = 32'd85004756;
			4:  r = 32'd42667331;
			5:  r = 32'd21354465;
			6:  r = 32'd10679838;
			7:  r = 32'd5340245;
			8:  r = 32'd2670163;
			9:  r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			24: r = 32'd41;
			25: r = 32'd20;
			26: r = 32'd10;
			27: r = 32'd5;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// (i+1) mod 3
	function automatic logic [1:0] idx_next(input logic [1:0] i);
		logic [1:0] r;
		case (i)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// (i+2) mod 3
	function automatic logic [1:0] idx_prev(input logic [1:0] i);
		logic [1:0] r;
		case (i)
			2'd0: r = 2'd2;
			2'd1: r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/auv_front.sv -----
// ----------------------------------------------------------------------------
// auv_front
// Wraps and folds the three angles, flags exact ones and plans the solve.
// ----------------------------------------------------------------------------
module auv_front
	import auv_pkg::*;
#(
	parameter int ANGLE_BITS = AUV_ANGLE_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  angles_t                 cmd,
	input  logic [9:0]              thr,
	output logic                    out_valid,
	output ctl_t                    ctl,
	output logic signed [ANGLE_BITS:0] angle [3]
);

	localparam int AW = ANGLE_BITS + 1;
	localparam logic signed [AW-1:0] HALF    = AW'(2 ** (ANGLE_BITS - 1));
	localparam logic signed [AW-1:0] QUARTER = AW'(2 ** (ANGLE_BITS - 2));
	localparam logic signed [AW-1:0] EIGHTH  = AW'(2 ** (ANGLE_BITS - 3));
	localparam logic [ANGLE_BITS-1:0] MIN_RAW = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	logic signed [15:0]        fld [3];
	logic signed [AW-1:0]      a_s1 [3];
	logic [ANGLE_BITS-1:0]     eps_s1 [3];
	logic [2:0]                rm_s1 [3];
	logic                      valid_s1;
	logic signed [AW-1:0]      thr_s;

	assign fld[0] = cmd.angle_xy;
	assign fld[1] = cmd.angle_yz;
	assign fld[2] = cmd.angle_zx;
	assign thr_s  = AW'(thr);

	for (genvar g = 0; g < 3; g++) begin : g_ang
		localparam int INV  = (g + 1) % 3;
		localparam int OUTV = (g + 2) % 3;
		logic [ANGLE_BITS-1:0] raw;
		logic signed [AW-1:0]  v, f, m, t, qmf, d;
		logic [1:0]            k;
		logic [2:0]            rm;
		logic [ANGLE_BITS-1:0] eps;

		always_comb begin
			raw = ANGLE_BITS'($unsigned(fld[g]));
			v   = (raw == MIN_RAW) ? HALF : AW'($signed(raw));
			m   = -v;
			t   = '0;
			k   = '0;
			f   = '0;
			if (v > 0) begin
				t = v - AW'(1);
				k = 2'(t >>> (ANGLE_BITS - 2));
				f = v - (AW'(k) << (ANGLE_BITS - 2));
			end else if (v < 0) begin
				t = m + QUARTER - AW'(1);
				k = 2'(t >>> (ANGLE_BITS - 2));
				f = (AW'(k) << (ANGLE_BITS - 2)) - m;
			end
			qmf = QUARTER - f;
			rm  = '0;
			if (f < thr_s) begin
				rm[k[0] ? INV : OUTV] = 1'b1;
			end else if (qmf < thr_s) begin
				rm[k[0] ? OUTV : INV] = 1'b1;
			end
			d   = (f >= EIGHTH) ? (f - EIGHTH) : (EIGHTH - f);
			eps = ANGLE_BITS'(d);
		end

		always_ff @(posedge clk) begin
			a_s1[g]   <= v;
			eps_s1[g] <= eps;
			rm_s1[g]  <= rm;
		end
	end

	ctl_t       ctl_d;
	logic [2:0] eq, eq_a, eq_b;
	logic [1:0] o0, o1, o2, tmp, e_idx, piv3, piv2, piv1;
	logic       dim3, ge2, ge1, flip;

	always_comb begin
		eq   = ~(rm_s1[0] | rm_s1[1] | rm_s1[2]);
		dim3 = (eq == 3'b111);
		tmp = 2'd0;
		o0 = 2'd0;
		o1 = 2'd1;
		o2 = 2'd2;
		// stable descending rank by distance from pi/4
		if (eps_s1[o0] < eps_s1[o1]) begin
			tmp = o0; o0 = o1; o1 = tmp;
		end
		if (eps_s1[o1] < eps_s1[o2]) begin
			tmp = o1; o1 = o2; o2 = tmp;
		end
		if (eps_s1[o0] < eps_s1[o1]) begin
			tmp = o0; o0 = o1; o1 = tmp;
		end
		flip = idx_next(o0) != idx_prev(o1);
		piv3 = flip ? idx_prev(o0) : idx_next(o0);
		eq_a = eq;
		if (dim3) eq_a[piv3] = 1'b0;
		ge2  = dim3 || ($countones(eq) == 2);
		e_idx = !eq_a[0] ? 2'd0 : (!eq_a[1] ? 2'd1 : 2'd2);
		piv2 = idx_next(e_idx);
		eq_b = eq_a;
		if (ge2) eq_b[piv2] = 1'b0;
		ge1  = ge2 || ($countones(eq) == 1);
		piv1 = eq_b[2] ? 2'd2 : (eq_b[1] ? 2'd1 : 2'd0);

		ctl_d.dim3   = dim3;
		ctl_d.ge2    = ge2;
		ctl_d.ge1    = ge1;
		ctl_d.r0     = o0;
		ctl_d.r1     = o1;
		ctl_d.flip   = flip;
		ctl_d.pivot3 = piv3;
		ctl_d.neg3   = flip ? a_s1[o0][AW-1] : a_s1[o1][AW-1];
		ctl_d.e_idx  = e_idx;
		ctl_d.pivot2 = piv2;
		ctl_d.neg2   = (a_s1[e_idx] >= QUARTER) || (a_s1[e_idx] <= -QUARTER);
		ctl_d.pivot1 = piv1;
		ctl_d.neg1   = a_s1[idx_next(piv1)][AW-1];
	end

	always_ff @(posedge clk) begin
		ctl   <= ctl_d;
		angle <= a_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

endmodule

// ----- hw/rtl/auv_cordic.sv -----
// ----------------------------------------------------------------------------
// auv_cordic
// One lane: folded angle through pipelined CORDIC rotations, then cos^2, sin^2.
// ----------------------------------------------------------------------------
module auv_cordic
	import auv_pkg::*;
#(
	parameter int ANGLE_BITS = AUV_ANGLE_BITS
) (
	input  logic                       clk,
	input  logic signed [ANGLE_BITS:0] angle,
	output q30_t                       cos_sq,
	output q30_t                       sin_sq
);

	localparam int AW = ANGLE_BITS + 1;
	localparam logic signed [AW-1:0] HALF    = AW'(2 ** (ANGLE_BITS - 1));
	localparam logic signed [AW-1:0] QUARTER = AW'(2 ** (ANGLE_BITS - 2));

	logic signed [AW-1:0] mag, th;
	logic signed [33:0]   x_s [0:CORDIC_N];
	logic signed [33:0]   y_s [0:CORDIC_N];
	logic signed [32:0]   z_s [0:CORDIC_N];

	always_comb begin
		mag = angle[AW-1] ? -angle : angle;
		th  = (mag > QUARTER) ? (HALF - mag) : mag;
	end

	always_ff @(posedge clk) begin
		x_s[0] <= CORDIC_GAIN;
		y_s[0] <= '0;
		z_s[0] <= 33'($unsigned(th)) << (32 - ANGLE_BITS);
	end

	for (genvar g = 0; g < CORDIC_N; g++) begin : g_rot
		localparam logic signed [32:0] ATAN = $signed({1'b0, atan_q(g)});
		always_ff @(posedge clk) begin
			if (!z_s[g][32]) begin
				x_s[g+1] <= x_s[g] - (y_s[g] >>> g);
				y_s[g+1] <= y_s[g] + (x_s[g] >>> g);
				z_s[g+1] <= z_s[g] - ATAN;
			end else begin
				x_s[g+1] <= x_s[g] + (y_s[g] >>> g);
				y_s[g+1] <= y_s[g] - (x_s[g] >>> g);
				z_s[g+1] <= z_s[g] + ATAN;
			end
		end
	end

	logic [33:0] xm, ym;
	logic [59:0] xp, yp;

	always_comb begin
		xm = x_s[CORDIC_N][33] ? 34'(-x_s[CORDIC_N]) : 34'(x_s[CORDIC_N]);
		ym = y_s[CORDIC_N][33] ? 34'(-y_s[CORDIC_N]) : 34'(y_s[CORDIC_N]);
		xp = xm[29:0] * xm[29:0];
		yp = ym[29:0] * ym[29:0];
	end

	// anything at or past one squares to at least one: saturate
	always_ff @(posedge clk) begin
		cos_sq <= (xm >= 34'(ONE_Q30)) ? ONE_Q30 : {1'b0, xp[59:30]};
		sin_sq <= (ym >= 34'(ONE_Q30)) ? ONE_Q30 : {1'b0, yp[59:30]};
	end

endmodule

// ----- hw/rtl/auv_div.sv -----
// ----------------------------------------------------------------------------
// auv_div
// Pipelined restoring divider, one quotient bit per stage, 31-bit quotient.
// ----------------------------------------------------------------------------
module auv_div
	import auv_pkg::*;
(
	input  logic        clk,
	input  logic [61:0] num,
	input  logic [32:0] dvs,
	output logic [30:0] quo
);

	logic [61:0] rem_s [0:DIV_Q_BITS];
	logic [32:0] dv_s  [0:DIV_Q_BITS];
	logic [30:0] q_s   [0:DIV_Q_BITS];

	assign rem_s[0] = num;
	assign dv_s[0]  = dvs;
	assign q_s[0]   = '0;

	for (genvar g = 0; g < DIV_Q_BITS; g++) begin : g_bit
		logic [63:0] trial;
		assign trial = {31'b0, dv_s[g]} << (DIV_Q_BITS - 1 - g);
		always_ff @(posedge clk) begin
			dv_s[g+1] <= dv_s[g];
			if ({2'b0, rem_s[g]} >= trial) begin
				rem_s[g+1] <= rem_s[g] - trial[61:0];
				q_s[g+1]   <= {q_s[g][29:0], 1'b1};
			end else begin
				rem_s[g+1] <= rem_s[g];
				q_s[g+1]   <= {q_s[g][29:0], 1'b0};
			end
		end
	end

	assign quo = q_s[DIV_Q_BITS];

endmodule

// ----- hw/rtl/auv_sqrt.sv -----
// ----------------------------------------------------------------------------
// auv_sqrt
// Pipelined integer floor square root of a Q60 value, one root bit per stage.
// ----------------------------------------------------------------------------
module auv_sqrt
	import auv_pkg::*;
(
	input  logic        clk,
	input  logic [60:0] rad,
	output logic [30:0] root
);

	logic [60:0] v_s [0:SQRT_STEPS];
	logic [60:0] r_s [0:SQRT_STEPS];

	assign v_s[0] = rad;
	assign r_s[0] = '0;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
		localparam logic [60:0] BIT = 61'(1) << (2 * (SQRT_STEPS - 1 - g));
		logic [61:0] trial;
		assign trial = {1'b0, r_s[g]} + {1'b0, BIT};
		always_ff @(posedge clk) begin
			if ({1'b0, v_s[g]} >= trial) begin
				v_s[g+1] <= v_s[g] - trial[60:0];
				r_s[g+1] <= (r_s[g] >> 1) + BIT;
			end else begin
				v_s[g+1] <= v_s[g];
				r_s[g+1] <= r_s[g] >> 1;
			end
		end
	end

	assign root = r_s[SQRT_STEPS][30:0];

endmodule

// ----- hw/rtl/angles_to_unit_vector_core.sv -----
// ----------------------------------------------------------------------------
// angles_to_unit_vector_core
// Three plane angles in, the unit vector they describe out, Q1.14.
// ----------------------------------------------------------------------------
//  channel   signals                         direction  handshake
//  command   start, busy, cmd                in         start & !busy
//  result    done, result                    out        done, one cycle
//  config    cfg_valid, cfg_ready, cfg_data  in         cfg_valid & cfg_ready
//
// One word enters per cycle; the pipeline holds the 28 CORDIC rotations, the
// 31-step divider and the 31-step root.
// busy stays low: nothing holds the pipeline, and done cannot be stalled.
// Reset clears valid bits and loads the zero threshold thr_q with 10.
// ----------------------------------------------------------------------------
module angles_to_unit_vector_core
	import auv_pkg::*;
#(
	parameter int ANGLE_BITS = AUV_ANGLE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  angles_t    cmd,
	output logic       done,
	output vec_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data
);

	localparam int AW = ANGLE_BITS + 1;

	logic [9:0] thr_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 10'd10;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// front: wrap, fold, flag, rank
	logic                 valid_s2;
	ctl_t                 ctl_s2;
	logic signed [AW-1:0] angle_s2 [3];

	auv_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.cmd       (cmd),
		.thr       (thr_q),
		.out_valid (valid_s2),
		.ctl       (ctl_s2),
		.angle     (angle_s2)
	);

	q30_t csq [3];
	q30_t ssq [3];

	for (genvar g = 0; g < 3; g++) begin : g_lane
		auv_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
			.clk    (clk),
			.angle  (angle_s2[g]),
			.cos_sq (csq[g]),
			.sin_sq (ssq[g])
		);
	end

	// carry the plan alongside the rotations
	ctl_t ctl_cd   [CORDIC_LAT];
	logic valid_cd [CORDIC_LAT];

	always_ff @(posedge clk) begin
		ctl_cd[0] <= ctl_s2;
		for (int i = 1; i < CORDIC_LAT; i++) ctl_cd[i] <= ctl_cd[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORDIC_LAT; i++) valid_cd[i] <= 1'b0;
		end else begin
			valid_cd[0] <= valid_s2;
			for (int i = 1; i < CORDIC_LAT; i++) valid_cd[i] <= valid_cd[i-1];
		end
	end

	// s3: ratio products
	ctl_t        ctl_c, ctl_s3;
	q30_t        c0, s0, c1, s1;
	logic [61:0] pa_s3, pb_s3, pc_s3;
	q30_t        ce_s3;
	logic        valid_s3;

	always_comb begin
		ctl_c = ctl_cd[CORDIC_LAT-1];
		c0 = csq[ctl_c.r0];
		s0 = ssq[ctl_c.r0];
		c1 = csq[ctl_c.r1];
		s1 = ssq[ctl_c.r1];
	end

	always_ff @(posedge clk) begin
		if (ctl_c.flip) begin
			pa_s3 <= s0 * c1;
			pb_s3 <= c0 * c1;
			pc_s3 <= s1 * s0;
		end else begin
			pa_s3 <= c0 * c1;
			pb_s3 <= c1 * s0;
			pc_s3 <= s1 * c0;
		end
		ce_s3  <= csq[ctl_c.e_idx];
		ctl_s3 <= ctl_c;
	end

	// s4: denominator
	logic [62:0] den;
	logic [61:0] num_s4;
	logic [32:0] dv_s4;
	q30_t        ce_s4;
	ctl_t        ctl_s4;
	logic        valid_s4;

	assign den = 63'(pa_s3) + 63'(pb_s3) + 63'(pc_s3);

	always_ff @(posedge clk) begin
		num_s4 <= pa_s3;
		dv_s4  <= den[62:30];
		ce_s4  <= ce_s3;
		ctl_s4 <= ctl_s3;
	end

	logic [30:0] quo;

	auv_div u_div (
		.clk (clk),
		.num (num_s4),
		.dvs (dv_s4),
		.quo (quo)
	);

	ctl_t ctl_dv   [DIV_Q_BITS];
	q30_t ce_dv    [DIV_Q_BITS];
	logic dz_dv    [DIV_Q_BITS];
	logic valid_dv [DIV_Q_BITS];

	always_ff @(posedge clk) begin
		ctl_dv[0] <= ctl_s4;
		ce_dv[0]  <= ce_s4;
		dz_dv[0]  <= (dv_s4 == '0);
		for (int i = 1; i < DIV_Q_BITS; i++) begin
			ctl_dv[i] <= ctl_dv[i-1];
			ce_dv[i]  <= ce_dv[i-1];
			dz_dv[i]  <= dz_dv[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			for (int i = 0; i < DIV_Q_BITS; i++) valid_dv[i] <= 1'b0;
		end else begin
			valid_s3    <= valid_cd[CORDIC_LAT-1];
			valid_s4    <= valid_s3;
			valid_dv[0] <= valid_s4;
			for (int i = 1; i < DIV_Q_BITS; i++) valid_dv[i] <= valid_dv[i-1];
		end
	end

	// s5: first solved component, what is left of one
	q30_t v2;
	q30_t rest1_s5, sq3_s5, ce_s5;
	ctl_t ctl_s5;
	logic valid_s5;

	always_comb begin
		if (dz_dv[DIV_Q_BITS-1]) v2 = '0;
		else v2 = (quo > ONE_Q30) ? ONE_Q30 : quo;
	end

	always_ff @(posedge clk) begin
		rest1_s5 <= ctl_dv[DIV_Q_BITS-1].dim3 ? (ONE_Q30 - v2) : ONE_Q30;
		sq3_s5   <= v2;
		ce_s5    <= ce_dv[DIV_Q_BITS-1];
		ctl_s5   <= ctl_dv[DIV_Q_BITS-1];
	end

	// s6: rest times cos^2 of the angle that governs the plane step
	logic [61:0] m_s6;
	q30_t        rest1_s6, sq3_s6;
	ctl_t        ctl_s6;
	logic        valid_s6;

	always_ff @(posedge clk) begin
		m_s6     <= rest1_s5 * ce_s5;
		rest1_s6 <= rest1_s5;
		sq3_s6   <= sq3_s5;
		ctl_s6   <= ctl_s5;
	end

	// s7: route squared values to their components
	q30_t        v2b, rest2;
	logic [60:0] rad_s7 [3];
	logic [2:0]  en_s7, neg_s7;
	logic        valid_s7;

	always_comb begin
		v2b   = 31'(m_s6 >> 30);
		rest2 = ctl_s6.ge2 ? (rest1_s6 - v2b) : rest1_s6;
	end

	for (genvar g = 0; g < 3; g++) begin : g_route
		logic en, neg;
		q30_t val;
		always_comb begin
			en  = 1'b1;
			neg = 1'b0;
			val = '0;
			if (ctl_s6.dim3 && ctl_s6.pivot3 == 2'(g)) begin
				val = sq3_s6;
				neg = ctl_s6.neg3;
			end else if (ctl_s6.ge2 && ctl_s6.pivot2 == 2'(g)) begin
				val = v2b;
				neg = ctl_s6.neg2;
			end else if (ctl_s6.ge1 && ctl_s6.pivot1 == 2'(g)) begin
				val = rest2;
				neg = ctl_s6.neg1;
			end else begin
				en = 1'b0;
			end
		end
		always_ff @(posedge clk) begin
			rad_s7[g] <= {val, 30'b0};
			en_s7[g]  <= en;
			neg_s7[g] <= neg;
		end
	end

	logic [30:0] root [3];

	for (genvar g = 0; g < 3; g++) begin : g_root
		auv_sqrt u_sqrt (
			.clk  (clk),
			.rad  (rad_s7[g]),
			.root (root[g])
		);
	end

	logic [2:0] en_sq    [SQRT_STEPS];
	logic [2:0] neg_sq   [SQRT_STEPS];
	logic       valid_sq [SQRT_STEPS];

	always_ff @(posedge clk) begin
		en_sq[0]  <= en_s7;
		neg_sq[0] <= neg_s7;
		for (int i = 1; i < SQRT_STEPS; i++) begin
			en_sq[i]  <= en_sq[i-1];
			neg_sq[i] <= neg_sq[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			for (int i = 0; i < SQRT_STEPS; i++) valid_sq[i] <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s5    <= valid_dv[DIV_Q_BITS-1];
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6;
			valid_sq[0] <= valid_s7;
			for (int i = 1; i < SQRT_STEPS; i++) valid_sq[i] <= valid_sq[i-1];
			done <= valid_sq[SQRT_STEPS-1];
		end
	end

	// s8: round to Q1.14, saturate, apply sign
	logic signed [15:0] comp [3];

	for (genvar g = 0; g < 3; g++) begin : g_out
		logic [31:0] sum;
		logic [15:0] qv;
		always_comb begin
			sum = 32'(root[g]) + 32'd32768;
			qv  = (sum[31:16] > 16'd16384) ? 16'd16384 : sum[31:16];
			if (!en_sq[SQRT_STEPS-1][g]) comp[g] = '0;
			else if (neg_sq[SQRT_STEPS-1][g]) comp[g] = -$signed(qv);
			else comp[g] = $signed(qv);
		end
	end

	always_ff @(posedge clk) begin
		result.comp_x <= comp[0];
		result.comp_y <= comp[1];
		result.comp_z <= comp[2];
	end

`ifndef ASSERT_OFF
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.comp_x <= 16'sd16384 && result.comp_x >= -16'sd16384 &&
		          result.comp_y <= 16'sd16384 && result.comp_y >= -16'sd16384 &&
		          result.comp_z <= 16'sd16384 && result.comp_z >= -16'sd16384))
		else $error("component outside Q1.14 unit range");

	a_pivots_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ctl_s2.dim3) |-> (ctl_s2.pivot3 != ctl_s2.pivot2 &&
		                               ctl_s2.pivot3 != ctl_s2.pivot1 &&
		                               ctl_s2.pivot2 != ctl_s2.pivot1))
		else $error("solve plan assigns one component twice");

	a_rest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (rest1_s5 <= ONE_Q30))
		else $error("remaining squared length exceeds one");

	a_enables: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |=> ($countones(en_s7) ==
		              $countones({$past(ctl_s6.dim3), $past(ctl_s6.ge2), $past(ctl_s6.ge1)})))
		else $error("component enables disagree with dimension");
`endif

endmodule
